/* rtl/tccw_pkg.sv */
package tccw_pkg;

  localparam int CODE_W  = 16;
  localparam int COLOR_W = 24;
  localparam int CELL_W  = CODE_W + COLOR_W;

  localparam logic [CODE_W-1:0] CH_TAB   = 16'd9;
  localparam logic [CODE_W-1:0] CH_LF    = 16'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 16'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 16'd32;

  // Red 255 in the low byte, green 100, blue 100.
  localparam logic [COLOR_W-1:0] ERROR_COLOR = 24'h6464FF;

  localparam logic [7:0]         COLUMNS_RESET    = 8'd80;
  localparam logic [6:0]         ROWS_RESET       = 7'd24;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_COLUMNS    = 2'd0,
    REG_ROWS       = 2'd1,
    REG_TEXT_COLOR = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_TAB,
    CMD_LF,
    CMD_CR,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [CODE_W-1:0]    code;
    logic [COLOR_W-1:0]   color;
    logic [5:0]           rrow;
    logic [6:0]           rcol;
  } cmd_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [6:0] rows;
  } geom_t;

endpackage

/* rtl/text_console_char_writer_unit.sv */
// Path: an item passes the input register and the two-entry queue, then the back-end
// sequencer: put, carriage return and line feed pass its execute state, a read also its
// read state, a tab writes spaces up to the next tab stop or the edge, and a line feed that scrolls clears a row.
// The sequencer takes the next item only in its idle state, once the last item is done and no stalled result is held.
// Reset: asynchronous and active low; afterwards the screen store is cleared one cell a
// cycle, all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (8192 by default), with input stalled.
module text_console_char_writer_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] char_code_i,
  input  logic        is_error_i,
  input  logic [5:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cursor_col_o,
  output logic [5:0]  cursor_row_o,
  output logic [15:0] cell_char_o,
  output logic [23:0] cell_color_o,
  output logic        scrolled_o
);
  import tccw_pkg::*;

  logic [7:0]         columns_q;
  logic [6:0]         rows_q;
  logic [COLOR_W-1:0] text_color_q;
  geom_t              geom;
  logic               back_ready;
  logic               f_push;
  cmd_t               f_cmd;
  logic               q_ready;
  logic               q_valid;
  cmd_t               q_head;
  logic               q_pop;

  assign cfg_ready_o  = 1'b1;
  assign geom.columns = columns_q;
  assign geom.rows    = rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= COLUMNS_RESET;
      rows_q       <= ROWS_RESET;
      text_color_q <= TEXT_COLOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COLUMNS:    columns_q    <= cfg_data_i[7:0];
        REG_ROWS:       rows_q       <= cfg_data_i[6:0];
        REG_TEXT_COLOR: text_color_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tccw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (back_ready),
    .text_color_i (text_color_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .is_error_i   (is_error_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .push_o       (f_push),
    .cmd_o        (f_cmd),
    .q_ready_i    (q_ready)
  );

  tccw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_push),
    .push_cmd_i (f_cmd),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  tccw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .ready_o      (back_ready),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

/* rtl/tccw_front.sv */
module tccw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          enable_i,
  input  logic [tccw_pkg::COLOR_W-1:0]  text_color_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [15:0]                   char_code_i,
  input  logic                          is_error_i,
  input  logic [5:0]                    read_row_i,
  input  logic [6:0]                    read_col_i,
  output logic                          push_o,
  output tccw_pkg::cmd_t                cmd_o,
  input  logic                          q_ready_i
);
  import tccw_pkg::*;

  logic  fv_q;
  cmd_t  fcmd_q;
  cmd_t  cls;
  logic  accept;

  always_comb begin
    cls.code  = char_code_i;
    cls.color = is_error_i ? ERROR_COLOR : text_color_i;
    cls.rrow  = read_row_i;
    cls.rcol  = read_col_i;
    priority if (op_i) begin
      cls.kind = CMD_READ;
    end else if (char_code_i == CH_LF) begin
      cls.kind = CMD_LF;
    end else if (char_code_i == CH_CR) begin
      cls.kind = CMD_CR;
    end else if (char_code_i == CH_TAB) begin
      cls.kind = CMD_TAB;
    end else begin
      cls.kind = CMD_PUT;
    end
  end

  assign in_stall_o = !enable_i || (fv_q && !q_ready_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = fv_q;
  assign cmd_o      = fcmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (q_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fcmd_q <= cls;
    end
  end

endmodule

/* rtl/tccw_queue.sv */
module tccw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tccw_pkg::cmd_t push_cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output tccw_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import tccw_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/tccw_back.sv */
module tccw_back #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tccw_pkg::geom_t geom_i,
  output logic           ready_o,
  input  logic           q_valid_i,
  input  tccw_pkg::cmd_t q_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     cursor_col_o,
  output logic [5:0]     cursor_row_o,
  output logic [15:0]    cell_char_o,
  output logic [23:0]    cell_color_o,
  output logic           scrolled_o
);
  import tccw_pkg::*;

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int AW   = RW + CW;
  localparam int KW   = $clog2(MAX_COLS + 1);
  localparam int TPW  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int CMPW = 10;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CLEAR
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [AW-1:0]     clr_addr_q;
  logic [KW-1:0]     col_q;
  logic [RW-1:0]     line_q;
  logic [RW-1:0]     top_q;
  logic [TPW-1:0]    phase_q;
  logic              rd_ok_q;
  logic              out_valid_q;
  logic [7:0]        o_col_q;
  logic [5:0]        o_row_q;
  logic [CODE_W-1:0] o_char_q;
  logic [COLOR_W-1:0] o_color_q;
  logic              o_scr_q;

  logic [CELL_W-1:0] mem [2**AW];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic [KW-1:0]     ncols;
  logic [RW:0]       nrows;
  logic              can_put;
  logic [KW-1:0]     col_nx;
  logic [TPW-1:0]    phase_nx;
  logic [RW:0]       line_inc;
  logic              need_scroll;
  logic [RW-1:0]     put_row;
  logic [RW-1:0]     rd_row;
  logic              rd_ok;
  logic [RW-1:0]     scroll_row;
  logic [RW-1:0]     top_nx;
  logic              out_free;
  logic              pop;
  logic              tab_more;

  // Row arithmetic modulo MAX_ROWS; operands stay below twice the modulus.
  function automatic logic [RW-1:0] row_add(input logic [RW:0] a, input logic [RW:0] b);
    logic [RW+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (RW+2)'(MAX_ROWS)) begin
      s = s - (RW+2)'(MAX_ROWS);
    end
    return s[RW-1:0];
  endfunction

  always_comb begin
    if ((CMPW)'(geom_i.columns) > (CMPW)'(MAX_COLS)) begin
      ncols = KW'(MAX_COLS);
    end else begin
      ncols = KW'(geom_i.columns);
    end
    if (geom_i.rows == 7'd0) begin
      nrows = (RW+1)'(1);
    end else if ((CMPW)'(geom_i.rows) > (CMPW)'(MAX_ROWS)) begin
      nrows = (RW+1)'(MAX_ROWS);
    end else begin
      nrows = (RW+1)'(geom_i.rows);
    end
  end

  assign can_put     = (col_q < ncols) && ((RW+1)'(line_q) < nrows);
  assign col_nx      = col_q + KW'(1);
  assign phase_nx    = (phase_q == TPW'(TAB_STOP - 1)) ? '0 : phase_q + TPW'(1);
  assign line_inc    = (RW+1)'(line_q) + (RW+1)'(1);
  assign need_scroll = (line_inc >= nrows);
  assign put_row     = row_add((RW+1)'(top_q), (RW+1)'(line_q));
  assign rd_row      = row_add((RW+1)'(top_q), (RW+1)'(cmd_q.rrow));
  assign rd_ok       = ((CMPW)'(cmd_q.rrow) < (CMPW)'(nrows)) &&
                       ((CMPW)'(cmd_q.rcol) < (CMPW)'(ncols));
  // The new bottom row sits at old top + rows once the top has advanced by one.
  assign scroll_row  = row_add((RW+1)'(top_q), nrows);
  assign top_nx      = row_add((RW+1)'(top_q), (RW+1)'(1));
  assign tab_more    = can_put && (phase_nx != '0);

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == S_IDLE) && q_valid_i && out_free;
  assign pop_o    = pop;
  assign ready_o  = (state_q != S_INIT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {rd_row, CW'(cmd_q.rcol)};
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        if ((cmd_q.kind == CMD_PUT || cmd_q.kind == CMD_TAB) && can_put) begin
          mem_we    = 1'b1;
          mem_waddr = {put_row, col_q[CW-1:0]};
          mem_wdata = {(cmd_q.kind == CMD_TAB) ? CH_SPACE : cmd_q.code, cmd_q.color};
        end
        mem_re = (cmd_q.kind == CMD_READ);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_addr_q  <= '0;
      col_q       <= '0;
      line_q      <= '0;
      top_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cmd_q   <= q_cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          o_char_q  <= '0;
          o_color_q <= '0;
          o_scr_q   <= 1'b0;
          unique case (cmd_q.kind)
            CMD_READ: begin
              rd_ok_q <= rd_ok;
              state_q <= S_READ;
            end
            CMD_PUT, CMD_TAB: begin
              if (can_put) begin
                col_q   <= col_nx;
                phase_q <= phase_nx;
              end
              // A tab keeps writing spaces until it reaches a stop or the edge.
              if (!(cmd_q.kind == CMD_TAB && tab_more)) begin
                out_valid_q <= 1'b1;
                o_col_q     <= 8'(can_put ? col_nx : col_q);
                o_row_q     <= 6'(line_q);
                state_q     <= S_IDLE;
              end
            end
            CMD_CR: begin
              col_q       <= '0;
              phase_q     <= '0;
              out_valid_q <= 1'b1;
              o_col_q     <= '0;
              o_row_q     <= 6'(line_q);
              state_q     <= S_IDLE;
            end
            CMD_LF: begin
              col_q   <= '0;
              phase_q <= '0;
              if (need_scroll) begin
                top_q      <= top_nx;
                line_q     <= RW'(nrows - (RW+1)'(1));
                clr_addr_q <= {scroll_row, CW'(0)};
                state_q    <= S_CLEAR;
              end else begin
                line_q      <= RW'(line_inc);
                out_valid_q <= 1'b1;
                o_col_q     <= '0;
                o_row_q     <= 6'(line_inc);
                state_q     <= S_IDLE;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          o_col_q     <= 8'(col_q);
          o_row_q     <= 6'(line_q);
          o_char_q    <= rd_ok_q ? rdata_q[CELL_W-1:COLOR_W] : '0;
          o_color_q   <= rd_ok_q ? rdata_q[COLOR_W-1:0] : '0;
          o_scr_q     <= 1'b0;
          state_q     <= S_IDLE;
        end
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q[CW-1:0] == CW'(MAX_COLS - 1)) begin
            out_valid_q <= 1'b1;
            o_col_q     <= '0;
            o_row_q     <= 6'(line_q);
            o_char_q    <= '0;
            o_color_q   <= '0;
            o_scr_q     <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = o_col_q;
  assign cursor_row_o = o_row_q;
  assign cell_char_o  = o_char_q;
  assign cell_color_o = o_color_q;
  assign scrolled_o   = o_scr_q;

endmodule

/* rtl/tccw_checker.sv */
module tccw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  cursor_col_o,
  input logic [5:0]  cursor_row_o,
  input logic [15:0] cell_char_o,
  input logic [23:0] cell_color_o,
  input logic        scrolled_o
);

  // A result beat held by the consumer stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cursor_col_o) && $stable(cursor_row_o)
      && $stable(cell_char_o) && $stable(cell_color_o) && $stable(scrolled_o))
    else $error("stalled result beat changed");

  // A scroll comes only from a line feed, which returns the cursor to the left edge.
  a_scroll_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_col_o == 8'd0)
    else $error("scroll left the cursor away from column zero");

  a_scroll_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cell_char_o == 16'd0 && cell_color_o == 24'd0)
    else $error("scroll result carries cell data");

endmodule

bind text_console_char_writer_unit tccw_checker u_tccw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o),
  .cell_char_o  (cell_char_o),
  .cell_color_o (cell_color_o),
  .scrolled_o   (scrolled_o)
);

/* bench/text_console_char_writer_unit_tb.sv */
`timescale 1ns / 100ps

module text_console_char_writer_unit_tb;
  import tccw_pkg::*;

  localparam int SCR_COLS  = 128;
  localparam int SCR_ROWS  = 64;
  localparam int TAB_W     = 4;
  localparam int CELLS     = SCR_COLS * SCR_ROWS;
  localparam int SETTLE_CYC = 160;  // covers a scrolling line feed plus the pipeline
  localparam int HOLD_CYC   = 400;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] code;
    logic        is_err;
    logic [5:0]  rrow;
    logic [6:0]  rcol;
  } console_in_t;

  typedef struct packed {
    logic [7:0]  col;
    logic [5:0]  row;
    logic [15:0] code;
    logic [23:0] color;
    logic        scrolled;
  } console_out_t;

  class console_scoreboard;
    logic [15:0] codes [CELLS];
    logic [23:0] colors [CELLS];
    int unsigned cur_col, cur_row, top_row;
    int unsigned columns, rows;
    logic [23:0] text_color;
    console_out_t answers_q[$];
    int unsigned errors, items, reads, scrolls, results;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        codes[i] = '0;
        colors[i] = '0;
      end
      cur_col = 0;
      cur_row = 0;
      top_row = 0;
      columns = COLUMNS_RESET;
      rows = ROWS_RESET;
      text_color = TEXT_COLOR_RESET;
    endfunction

    function int unsigned used_cols();
      return (columns > SCR_COLS) ? SCR_COLS : columns;
    endfunction

    function int unsigned used_rows();
      if (rows == 0) return 1;
      return (rows > SCR_ROWS) ? SCR_ROWS : rows;
    endfunction

    function int unsigned cell_at(int unsigned vrow, int unsigned col);
      return ((top_row + vrow) % SCR_ROWS) * SCR_COLS + (col % SCR_COLS);
    endfunction

    function int unsigned outstanding();
      return answers_q.size();
    endfunction

    function void configure(reg_idx_e idx, logic [23:0] data);
      case (idx)
        REG_COLUMNS: columns = data[7:0];
        REG_ROWS: rows = data[6:0];
        REG_TEXT_COLOR: text_color = data;
        default: ;
      endcase
    endfunction

    // Characters at or past the right edge, or on a row below the screen, are dropped.
    function void write_cell(logic [15:0] code, logic [23:0] color);
      int unsigned i;
      if (cur_col >= used_cols() || cur_row >= used_rows()) return;
      i = cell_at(cur_row, cur_col);
      codes[i] = code;
      colors[i] = color;
      cur_col++;
    endfunction

    function void note_item(console_in_t it);
      console_out_t r;
      logic [23:0] color;
      int unsigned nrows, base, span;
      r = '0;
      nrows = used_rows();
      items++;
      if (it.op == OP_READ) begin
        reads++;
        if (it.rrow < nrows && it.rcol < used_cols()) begin
          r.code = codes[cell_at(it.rrow, it.rcol)];
          r.color = colors[cell_at(it.rrow, it.rcol)];
        end
      end else begin
        color = it.is_err ? ERROR_COLOR : text_color;
        if (it.code == CH_LF) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= nrows) begin
            // The whole new bottom store row is blanked, not just the columns in use.
            top_row = (top_row + 1) % SCR_ROWS;
            base = cell_at(nrows - 1, 0);
            for (int k = 0; k < SCR_COLS; k++) begin
              codes[base + k] = '0;
              colors[base + k] = '0;
            end
            cur_row = nrows - 1;
            r.scrolled = 1'b1;
            scrolls++;
          end
        end else if (it.code == CH_CR) begin
          cur_col = 0;
        end else if (it.code == CH_TAB) begin
          span = TAB_W - (cur_col % TAB_W);
          repeat (span) write_cell(CH_SPACE, color);
        end else begin
          write_cell(it.code, color);
        end
      end
      r.col = 8'(cur_col);
      r.row = 6'(cur_row);
      answers_q = {answers_q, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(console_out_t got);
      console_out_t want;
      if (answers_q.size() == 0) begin
        report($sformatf("result with nothing pending (col %0d row %0d)", got.col, got.row));
        return;
      end
      want = answers_q.pop_front();
      results++;
      if (got.col !== want.col)
        report($sformatf("beat %0d cursor_col %0d, want %0d", results, got.col, want.col));
      if (got.row !== want.row)
        report($sformatf("beat %0d cursor_row %0d, want %0d", results, got.row, want.row));
      if (got.code !== want.code)
        report($sformatf("beat %0d cell_char %h, want %h", results, got.code, want.code));
      if (got.color !== want.color)
        report($sformatf("beat %0d cell_color %h, want %h", results, got.color, want.color));
      if (got.scrolled !== want.scrolled)
        report($sformatf("beat %0d scrolled %b, want %b", results, got.scrolled,
                         want.scrolled));
    endtask

    task flush_leftovers();
      if (answers_q.size() != 0)
        report($sformatf("%0d results never arrived", answers_q.size()));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [15:0] char_code_i = '0;
  logic        is_error_i = 1'b0;
  logic [5:0]  read_row_i = '0;
  logic [6:0]  read_col_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  cursor_col_o;
  logic [5:0]  cursor_row_o;
  logic [15:0] cell_char_o;
  logic [23:0] cell_color_o;
  logic        scrolled_o;

  console_scoreboard sb;
  bit          quiet_run = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned settings = 0;

  text_console_char_writer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .is_error_i   (is_error_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o),
    .scrolled_o   (scrolled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("text_console_char_writer_unit verification failed");
    $finish;
  end

  // Result side: check every beat, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({cursor_col_o, cursor_row_o, cell_char_o, cell_color_o, scrolled_o});
      if (holds_done != holds_asked) begin
        holds_done <= holds_asked;
        hold_left <= HOLD_CYC;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_run && ($urandom_range(99) < 12);
      end
    end
  end

  task automatic send_item(console_in_t it);
    while (!quiet_run && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    char_code_i <= it.code;
    is_error_i <= it.is_err;
    read_row_i <= it.rrow;
    read_col_i <= it.rcol;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  // Stop offering input and wait until every pending result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.configure(idx, data);
  endtask

  task automatic program_screen(logic [23:0] cols_w, logic [23:0] rows_w, logic [23:0] color_w);
    settle();
    write_reg(REG_COLUMNS, cols_w);
    write_reg(REG_ROWS, rows_w);
    write_reg(REG_TEXT_COLOR, color_w);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic console_in_t put_item(logic [15:0] code, logic err);
    console_in_t it;
    it.op = OP_PUT;
    it.code = code;
    it.is_err = err;
    it.rrow = 6'($urandom);
    it.rcol = 7'($urandom);
    return it;
  endfunction

  function automatic console_in_t read_item(logic [5:0] row, logic [6:0] col);
    console_in_t it;
    it.op = OP_READ;
    it.code = 16'($urandom);
    it.is_err = 1'($urandom);
    it.rrow = row;
    it.rcol = col;
    return it;
  endfunction

  // Mostly text with line breaks and tabs, plus reads that mostly land on the screen.
  function automatic console_in_t random_item();
    console_in_t it;
    int unsigned pick;
    it = put_item(16'($urandom_range(32, 126)), $urandom_range(3) == 0);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it = read_item(6'($urandom), 7'($urandom));
      if ($urandom_range(4) != 0) begin
        it.rrow = 6'($urandom_range(0, sb.used_rows() - 1));
        if (sb.used_cols() != 0) it.rcol = 7'($urandom_range(0, sb.used_cols() - 1));
      end
    end else if (pick < 37) begin
      it.code = CH_LF;
    end else if (pick < 44) begin
      it.code = CH_TAB;
    end else if (pick < 49) begin
      it.code = CH_CR;
    end else if (pick < 70) begin
      it.code = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    int unsigned ph_cols [9];
    int unsigned ph_rows [9];
    int unsigned ph_color [9];
    int unsigned ph_len [9];
    sb = new();
    ph_cols  = '{80, 128, 1, 255, 0, 4, $urandom_range(1, 128), $urandom, 16};
    ph_rows  = '{24, 64, 1, 127, 0, 3, $urandom_range(1, 64), $urandom, 8};
    ph_color = '{24'hFFFFFF, 0, $urandom, 24'hFFFFFF, $urandom, $urandom, $urandom,
                 $urandom, 24'h00FF00};
    ph_len   = '{200, 220, 120, 160, 50, 180, 150, 150, 150};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: plain, error-colored and zero codes, tabs, reads in and out of range.
    send_item(put_item(16'h0048, 1'b0));
    send_item(put_item(16'hFFFF, 1'b1));
    send_item(put_item(16'h0000, 1'b0));
    send_item(put_item(CH_TAB, 1'b0));
    send_item(put_item(CH_TAB, 1'b1));
    send_item(read_item(6'd0, 7'd0));
    send_item(read_item(6'd0, 7'd1));
    send_item(read_item(6'd0, 7'd5));
    send_item(read_item(6'd63, 7'd127));
    send_item(read_item(6'd0, 7'd80));
    send_item(read_item(6'd23, 7'd79));
    send_item(put_item(CH_CR, 1'b0));
    send_item(put_item(CH_LF, 1'b0));
    send_item(put_item(16'h0078, 1'b0));

    // Shrink below the cursor: the write is dropped and the line feed scrolls onto row 0.
    program_screen(24'd2, 24'd1, 24'h123456);
    send_item(put_item(16'h0079, 1'b0));
    send_item(put_item(CH_LF, 1'b0));
    send_item(put_item(16'h0061, 1'b0));
    send_item(put_item(16'h0062, 1'b1));
    send_item(put_item(16'h0063, 1'b0));
    send_item(put_item(CH_TAB, 1'b0));
    send_item(read_item(6'd0, 7'd1));

    // Zero columns drop everything; zero rows act as one.
    program_screen(24'd0, 24'd0, 24'h000000);
    send_item(put_item(16'h007A, 1'b0));
    send_item(put_item(CH_TAB, 1'b0));

    // Growing again exposes old store rows.
    program_screen(24'd128, 24'd64, 24'hFFFFFF);
    send_item(read_item(6'd63, 7'd0));
    send_item(read_item(6'd63, 7'd127));

    for (int p = 0; p < 9; p++) begin
      program_screen(24'(ph_cols[p]), 24'(ph_rows[p]), 24'(ph_color[p]));
      quiet_run <= (p == 3);
      for (int n = 0; n < ph_len[p]; n++) begin
        if (p == 1 && n == 60) holds_asked <= holds_asked + 1;
        if (p == 5 && n == 90) settle();
        send_item(random_item());
      end
    end

    settle();
    repeat (200) @(posedge clk_i);
    sb.flush_leftovers();
    $display("Ran %0d items (%0d reads, %0d scrolls) across %0d screen settings.",
             sb.items, sb.reads, sb.scrolls, settings);
    $display("Compared %0d result beats field by field, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("text_console_char_writer_unit verification clean");
    end else begin
      $display("text_console_char_writer_unit verification failed");
    end
    $finish;
  end

endmodule
